// ===== rtl/sorted_timer_queue_unit_assert.svh =====
// Assertion macros shared by the RTL. Each expects clk and rst in scope.
`ifndef SORTED_TIMER_QUEUE_UNIT_ASSERT_SVH
`define SORTED_TIMER_QUEUE_UNIT_ASSERT_SVH

// cond holds at every clock edge outside reset
`define STQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons holds in the same cycle as ante
`define STQ_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons holds in the cycle after ante
`define STQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/stq_pkg.sv =====
`default_nettype none
package stq_pkg;
  localparam int SLOTS          = 32;
  localparam int NUM_TIMERS_DEF = 32;
  localparam int SLOT_W         = 5;
  localparam int CNT_W          = 6;
  localparam int TIME_W         = 32;
  localparam logic [TIME_W-1:0] TIME_MAX = 32'hFFFF_FFFF;

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_ALLOC    = 3'd1;
  localparam logic [2:0] OP_FREE     = 3'd2;
  localparam logic [2:0] OP_SET_DATA = 3'd3;
  localparam logic [2:0] OP_SET_TIME = 3'd4;

  localparam logic [1:0] KIND_DONE    = 2'd0;
  localparam logic [1:0] KIND_ALLOC   = 2'd1;
  localparam logic [1:0] KIND_FAIL    = 2'd2;
  localparam logic [1:0] KIND_EXPIRED = 2'd3;

  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_ARMED = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/stq_ram.sv =====
`default_nettype none
module stq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/sorted_timer_queue_unit.sv =====
`default_nettype none
// Channel   Direction  Ports                                               Transaction
// command   in         start, busy, operation, timer_index, delay_ticks,   start && !busy
//                      payload, destination
// result    out        result_valid, kind, slot, expired_data,             result_valid
//                      expired_destination, last
//
// Alloc, set data, free of an unarmed slot and ignored commands do not touch the list; nor
// does a tick with nothing due. A tick that expires timers walks them from the list head
// and then shifts the remaining entries down.
// Set time unlinks an armed slot, then runs an ordered search and shifts the tail up.
// Free of an armed slot unlinks it; every list change ends by reloading the next deadline.
// Reset: synchronous; the list comes up empty and all slots free, no clearing pass.
// Stalls: the receiver cannot stall; busy holds new commands off until the last result.
module sorted_timer_queue_unit #(
  parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  operation,
  input  wire logic [4:0]  timer_index,
  input  wire logic [31:0] delay_ticks,
  input  wire logic [7:0]  payload,
  input  wire logic [3:0]  destination,
  output logic             result_valid,
  output logic [1:0]       kind,
  output logic [4:0]       slot,
  output logic [7:0]       expired_data,
  output logic [3:0]       expired_destination,
  output logic             last
);
  localparam int LIVE = (NUM_TIMERS < stq_pkg::SLOTS) ? NUM_TIMERS : stq_pkg::SLOTS;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_T_ORD = 5'd1;
  localparam logic [4:0] S_T_DL  = 5'd2;
  localparam logic [4:0] S_T_CMP = 5'd3;
  localparam logic [4:0] S_UL_RD = 5'd4;
  localparam logic [4:0] S_UL_CK = 5'd5;
  localparam logic [4:0] S_SD_RD = 5'd6;
  localparam logic [4:0] S_SD_WR = 5'd7;
  localparam logic [4:0] S_IN_RD = 5'd8;
  localparam logic [4:0] S_IN_DL = 5'd9;
  localparam logic [4:0] S_IN_CK = 5'd10;
  localparam logic [4:0] S_SU_RD = 5'd11;
  localparam logic [4:0] S_SU_WR = 5'd12;
  localparam logic [4:0] S_RF_A  = 5'd13;
  localparam logic [4:0] S_RF_B  = 5'd14;
  localparam logic [4:0] S_RF_C  = 5'd15;
  localparam logic [4:0] S_DONE  = 5'd16;

  logic [4:0]  state;
  logic [31:0] tick_count;
  logic [31:0] next_deadline;
  logic [5:0]  active_count;
  logic [1:0]  slot_status [stq_pkg::SLOTS];

  // per-command working registers
  logic [2:0]  op;
  logic [4:0]  cur;        // slot addressed by the command, or slot under test in a tick
  logic [31:0] deadline;   // new deadline for set time
  logic [5:0]  ptr;        // list position for scans and downward shifts
  logic [5:0]  wptr;       // write position for the upward shift
  logic [5:0]  shift_k;    // distance of the downward shift
  logic [5:0]  n_expired;

  // result waiting to be shown; it becomes last once the walk knows nothing more is due
  logic [1:0]  pend_kind;
  logic [4:0]  pend_slot;
  logic [7:0]  pend_data;
  logic [3:0]  pend_dest;

  // memory ports
  logic        ord_we;
  logic [4:0]  ord_waddr, ord_wdata, ord_raddr, ord_rdata;
  logic [31:0] dl_rdata;
  logic [11:0] dat_rdata;
  logic        accept;
  logic        idx_live;
  logic        free_found;
  logic [4:0]  free_slot;
  logic [31:0] tick_inc;
  logic [6:0]  sd_src;
  logic        emit;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign idx_live = ({27'd0, timer_index} < 32'(LIVE));
  assign tick_inc = tick_count + 32'd1;
  assign sd_src   = {1'b0, ptr} + {1'b0, shift_k};

  // show a result at the end of a command, or release a held expiry when another follows
  assign emit = (state == S_DONE) ||
                (state == S_T_CMP && !(dl_rdata > tick_count) &&
                 pend_kind == stq_pkg::KIND_EXPIRED);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int s = stq_pkg::SLOTS - 1; s >= 0; s--) begin
      if (s < LIVE && slot_status[s] == stq_pkg::ST_FREE) begin
        free_found = 1'b1;
        free_slot  = 5'(s);
      end
    end
  end

  // order list read address and write port
  always_comb begin
    ord_raddr = '0;
    ord_we    = 1'b0;
    ord_waddr = '0;
    ord_wdata = '0;
    unique case (state)
      S_T_ORD: ord_raddr = n_expired[4:0];
      S_UL_RD, S_IN_RD: ord_raddr = ptr[4:0];
      S_SD_RD: ord_raddr = sd_src[4:0];
      S_SD_WR: begin
        ord_we    = 1'b1;
        ord_waddr = ptr[4:0];
        ord_wdata = ord_rdata;
      end
      S_SU_RD: begin
        if (wptr > ptr) begin
          ord_raddr = 5'(wptr - 6'd1);
        end else begin
          ord_we    = 1'b1;
          ord_waddr = ptr[4:0];
          ord_wdata = cur;
        end
      end
      S_SU_WR: begin
        ord_we    = 1'b1;
        ord_waddr = wptr[4:0];
        ord_wdata = ord_rdata;
      end
      default: ord_raddr = '0;
    endcase
  end

  stq_ram #(.WIDTH(stq_pkg::SLOT_W), .DEPTH(stq_pkg::SLOTS)) u_order (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );

  // deadline and data are always looked up for the slot the list just returned
  stq_ram #(.WIDTH(stq_pkg::TIME_W), .DEPTH(stq_pkg::SLOTS)) u_deadline (
    .clk(clk), .we(accept && operation == stq_pkg::OP_SET_TIME && idx_live),
    .waddr(timer_index), .wdata(tick_count + delay_ticks),
    .raddr(ord_rdata), .rdata(dl_rdata)
  );

  stq_ram #(.WIDTH(12), .DEPTH(stq_pkg::SLOTS)) u_data (
    .clk(clk), .we(accept && operation == stq_pkg::OP_SET_DATA && idx_live),
    .waddr(timer_index), .wdata({destination, payload}),
    .raddr(ord_rdata), .rdata(dat_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      tick_count    <= '0;
      next_deadline <= stq_pkg::TIME_MAX;
      active_count  <= '0;
      for (int s = 0; s < stq_pkg::SLOTS; s++) begin
        slot_status[s] <= stq_pkg::ST_FREE;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op        <= operation;
            cur       <= timer_index;
            deadline  <= tick_count + delay_ticks;
            ptr       <= '0;
            n_expired <= '0;
            pend_kind <= stq_pkg::KIND_DONE;
            pend_slot <= '0;
            pend_data <= '0;
            pend_dest <= '0;
            state     <= S_DONE;
            if (operation == stq_pkg::OP_TICK) begin
              tick_count <= tick_inc;
              if (!(next_deadline > tick_inc)) begin
                state <= (active_count == '0) ? S_RF_A : S_T_ORD;
              end
            end else if (operation == stq_pkg::OP_ALLOC) begin
              if (free_found) begin
                slot_status[free_slot] <= stq_pkg::ST_ALLOC;
                pend_kind <= stq_pkg::KIND_ALLOC;
                pend_slot <= free_slot;
              end else begin
                pend_kind <= stq_pkg::KIND_FAIL;
              end
            end else if (idx_live) begin
              if (operation == stq_pkg::OP_FREE) begin
                slot_status[timer_index] <= stq_pkg::ST_FREE;
                if (slot_status[timer_index] == stq_pkg::ST_ARMED) begin
                  state <= S_UL_RD;
                end
              end else if (operation == stq_pkg::OP_SET_TIME) begin
                slot_status[timer_index] <= stq_pkg::ST_ARMED;
                state <= (slot_status[timer_index] == stq_pkg::ST_ARMED) ? S_UL_RD : S_IN_RD;
              end
            end
          end
        end

        // expiry walk: read the next list entry, then its deadline, then compare
        S_T_ORD: state <= S_T_DL;
        S_T_DL: begin
          cur   <= ord_rdata;
          state <= S_T_CMP;
        end
        S_T_CMP: begin
          if (!(dl_rdata > tick_count)) begin
            slot_status[cur] <= stq_pkg::ST_ALLOC;
            if (pend_kind == stq_pkg::KIND_EXPIRED) begin
              // a further expiry follows: release the held one as not last
              kind                <= pend_kind;
              slot                <= pend_slot;
              expired_data        <= pend_data;
              expired_destination <= pend_dest;
              last                <= 1'b0;
            end
            pend_kind <= stq_pkg::KIND_EXPIRED;
            pend_slot <= cur;
            pend_data <= dat_rdata[7:0];
            pend_dest <= dat_rdata[11:8];
            n_expired <= n_expired + 6'd1;
            if (n_expired + 6'd1 < active_count) begin
              state <= S_T_ORD;
            end else begin
              ptr     <= '0;
              shift_k <= n_expired + 6'd1;
              state   <= S_SD_RD;
            end
          end else begin
            ptr     <= '0;
            shift_k <= n_expired;
            state   <= S_SD_RD;
          end
        end

        // find the slot in the list, then close the gap
        S_UL_RD: begin
          if (ptr < active_count) begin
            state <= S_UL_CK;
          end else begin
            ptr   <= '0;
            state <= (op == stq_pkg::OP_SET_TIME) ? S_IN_RD : S_RF_A;
          end
        end
        S_UL_CK: begin
          if (ord_rdata == cur) begin
            shift_k <= 6'd1;
            state   <= S_SD_RD;
          end else begin
            ptr   <= ptr + 6'd1;
            state <= S_UL_RD;
          end
        end

        S_SD_RD: begin
          if (sd_src < {1'b0, active_count}) begin
            state <= S_SD_WR;
          end else begin
            active_count <= active_count - shift_k;
            ptr          <= '0;
            state        <= (op == stq_pkg::OP_SET_TIME) ? S_IN_RD : S_RF_A;
          end
        end
        S_SD_WR: begin
          ptr   <= ptr + 6'd1;
          state <= S_SD_RD;
        end

        // ordered search: stop at the first deadline not below the new one
        S_IN_RD: begin
          if (ptr < active_count) begin
            state <= S_IN_DL;
          end else begin
            wptr  <= active_count;
            state <= S_SU_RD;
          end
        end
        S_IN_DL: state <= S_IN_CK;
        S_IN_CK: begin
          if (dl_rdata >= deadline) begin
            wptr  <= active_count;
            state <= S_SU_RD;
          end else begin
            ptr   <= ptr + 6'd1;
            state <= S_IN_RD;
          end
        end

        // open a hole at ptr, moving the tail up one entry at a time
        S_SU_RD: begin
          if (wptr > ptr) begin
            state <= S_SU_WR;
          end else begin
            active_count <= active_count + 6'd1;
            state        <= S_RF_A;
          end
        end
        S_SU_WR: begin
          wptr  <= wptr - 6'd1;
          state <= S_SU_RD;
        end

        // next deadline from the list head
        S_RF_A: begin
          if (active_count == '0) begin
            next_deadline <= stq_pkg::TIME_MAX;
            state         <= S_DONE;
          end else begin
            state <= S_RF_B;
          end
        end
        S_RF_B: state <= S_RF_C;
        S_RF_C: begin
          next_deadline <= dl_rdata;
          state         <= S_DONE;
        end

        S_DONE: begin
          kind                <= pend_kind;
          slot                <= pend_slot;
          expired_data        <= pend_data;
          expired_destination <= pend_dest;
          last                <= 1'b1;
          state               <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`include "sorted_timer_queue_unit_assert.svh"

  `STQ_ASSERT_ALWAYS(a_list_bound, active_count <= 6'd32, "list longer than the pool")
  `STQ_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "command accepted but not busy")
  `STQ_ASSERT_IMPLY(a_more_follows, result_valid && !last, busy, "non-last result while idle")
  `STQ_ASSERT_IMPLY(a_empty_deadline, state == S_IDLE && active_count == '0, next_deadline == stq_pkg::TIME_MAX, "empty list with a deadline")
endmodule
`default_nettype wire
